// File: rtl/homogeneous_vertex_transform_top_defines.svh
// ----------------------------------------------------------------------------
// homogeneous vertex transform - assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_TOP_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication
`define HVT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hvt check failed");

// next-cycle implication
`define HVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hvt check failed");

`endif

// File: rtl/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared widths, types and constants of the homogeneous vertex transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvt_pkg;

    // fixed-point defaults and field widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int VEC_N         = 4;
    localparam int TDATA_W       = DATA_W * VEC_N;

    // configuration port
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int BYTE_OFS_W = 3;
    localparam int APB_ADDR_W = REG_IDX_W + BYTE_OFS_W;
    localparam int APB_DATA_W = 64;

    // saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // one vector or one matrix row, element 0 in the lowest bits
    typedef logic [VEC_N-1:0][DATA_W-1:0] t_vec;

    // whole matrix, indexed [row][col]
    typedef logic [VEC_N-1:0][VEC_N-1:0][DATA_W-1:0] t_matrix;

    // per-stage load enables of the datapath
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } t_pipe_ctl;

endpackage

// File: rtl/hvt_cfg_regs.sv
// ----------------------------------------------------------------------------
// hvt_cfg_regs
// APB register file holding the 4x4 matrix, two entries per 64-bit register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvt_cfg_regs #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hvt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hvt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hvt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output hvt_pkg::t_matrix                  o_matrix
);

    localparam int DW = hvt_pkg::DATA_W;
    localparam logic [DW-1:0] FIX_ONE = DW'(1) << FRAC_BITS;

    logic [hvt_pkg::APB_DATA_W-1:0]   r_mat_reg [hvt_pkg::NUM_REGS];
    logic [hvt_pkg::REG_IDX_W-1:0]    w_idx;
    logic                             w_wr_en;

    // identity matrix value of one register
    function automatic logic [hvt_pkg::APB_DATA_W-1:0] f_reset_val(input int unsigned idx);
        logic [hvt_pkg::APB_DATA_W-1:0] v;
        int unsigned                    row;
        int unsigned                    col0;
        v    = '0;
        row  = idx >> 1;
        col0 = (idx & 1) << 1;
        if (row == col0)
            v[DW-1:0] = FIX_ONE;
        if (row == col0 + 1)
            v[2*DW-1:DW] = FIX_ONE;
        return v;
    endfunction

    // write decode
    assign w_idx   = paddr[hvt_pkg::APB_ADDR_W-1:hvt_pkg::BYTE_OFS_W];
    assign w_wr_en = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    // register array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hvt_pkg::NUM_REGS; i++)
                r_mat_reg[i] <= f_reset_val(i);
        end else if (w_wr_en) begin
            r_mat_reg[w_idx] <= pwdata;
        end
    end

    // read back
    assign prdata = r_mat_reg[w_idx];

    // matrix view: register 2r holds cols 0/1, register 2r+1 holds cols 2/3
    always_comb begin
        for (int r = 0; r < hvt_pkg::VEC_N; r++) begin
            o_matrix[r][0] = r_mat_reg[2*r][DW-1:0];
            o_matrix[r][1] = r_mat_reg[2*r][2*DW-1:DW];
            o_matrix[r][2] = r_mat_reg[2*r+1][DW-1:0];
            o_matrix[r][3] = r_mat_reg[2*r+1][2*DW-1:DW];
        end
    end

endmodule

// File: rtl/hvt_row_dot.sv
// ----------------------------------------------------------------------------
// hvt_row_dot
// Four-stage dot product of one matrix row with the vertex, saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvt_row_dot #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  hvt_pkg::t_pipe_ctl           i_ctl,
    input  hvt_pkg::t_vec                i_row,
    input  hvt_pkg::t_vec                i_vec,
    output logic [hvt_pkg::DATA_W-1:0]   o_out
);

    localparam int DW     = hvt_pkg::DATA_W;
    localparam int N      = hvt_pkg::VEC_N;
    localparam int PROD_W = 2 * DW;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int PAIR_W = SH_W + 1;
    localparam int SUM_W  = SH_W + 2;

    logic signed [PROD_W-1:0] n_prod [N];
    logic signed [PROD_W-1:0] r_prod [N];
    logic signed [SH_W-1:0]   w_sh   [N];
    logic signed [PAIR_W-1:0] n_pair_lo, n_pair_hi;
    logic signed [PAIR_W-1:0] r_pair_lo, r_pair_hi;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  r_sum;
    logic [DW-1:0]            n_out;
    logic [DW-1:0]            r_out;
    logic                     w_fits;

    // stage 1: one signed 32x32 multiply per column
    always_comb begin
        for (int c = 0; c < N; c++)
            n_prod[c] = PROD_W'($signed(i_row[c])) * PROD_W'($signed(i_vec[c]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_en)
            r_prod <= n_prod;
    end

    // stage 2: floor shift (drop fraction bits) and pairwise add
    always_comb begin
        for (int c = 0; c < N; c++)
            w_sh[c] = $signed(r_prod[c][PROD_W-1:FRAC_BITS]);
        n_pair_lo = PAIR_W'(w_sh[0]) + PAIR_W'(w_sh[1]);
        n_pair_hi = PAIR_W'(w_sh[2]) + PAIR_W'(w_sh[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_en) begin
            r_pair_lo <= n_pair_lo;
            r_pair_hi <= n_pair_hi;
        end
    end

    // stage 3: full sum
    assign n_sum = SUM_W'(r_pair_lo) + SUM_W'(r_pair_hi);

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_en)
            r_sum <= n_sum;
    end

    // stage 4: saturate to the signed 32-bit range
    assign w_fits = (r_sum[SUM_W-1:DW-1] == '0) || (r_sum[SUM_W-1:DW-1] == '1);

    always_comb begin
        if (w_fits)
            n_out = r_sum[DW-1:0];
        else if (r_sum[SUM_W-1])
            n_out = hvt_pkg::SAT_MIN;
        else
            n_out = hvt_pkg::SAT_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s4_en)
            r_out <= n_out;
    end

    assign o_out = r_out;

endmodule

// File: rtl/homogeneous_vertex_transform_top.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_top
// 4x4 matrix times homogeneous vertex, Q16.16 fixed point, saturated output.
//
//   channel   | direction | payload
//   ----------+-----------+----------------------------------------------
//   s stream  | in        | vec_x, vec_y, vec_z, vec_w (32 bits each)
//   m stream  | out       | out_x, out_y, out_z, out_w (32 bits each)
//   apb       | in / out  | eight 64-bit matrix registers at 8*i
//
// one vertex per clock while the output is not stalled; a vertex passes the product,
// pair-sum, sum and output registers before it shows as valid on the output
// stages: 16 multipliers, pair add, full add, saturate into output register
// reset loads the identity matrix and empties the pipeline
// a stall at the output holds each stage; stages with no valid item still
// fill, so the input stays ready while any bubble is left in the pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module homogeneous_vertex_transform_top #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [hvt_pkg::TDATA_W-1:0]      i_s_tdata,   // vec_x, vec_y, vec_z, vec_w
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [hvt_pkg::TDATA_W-1:0]      o_m_tdata,   // out_x, out_y, out_z, out_w
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hvt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hvt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hvt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int NSTG = 4;

    hvt_pkg::t_matrix    w_matrix;
    hvt_pkg::t_vec       w_vec;
    hvt_pkg::t_vec       w_out;
    hvt_pkg::t_pipe_ctl  w_ctl;
    logic [NSTG-1:0]     r_vld;
    logic [NSTG-1:0]     n_vld;
    logic [NSTG-1:0]     w_rdy;

    // matrix registers
    hvt_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_matrix (w_matrix)
    );

    // ready chain: a stage loads when empty or when the next one loads
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    assign w_ctl.s1_en = w_rdy[0];
    assign w_ctl.s2_en = w_rdy[1];
    assign w_ctl.s3_en = w_rdy[2];
    assign w_ctl.s4_en = w_rdy[3];

    // valid bits travel with the data
    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0])
            n_vld[0] = i_s_tvalid;
        for (int k = 1; k < NSTG; k++) begin
            if (w_rdy[k])
                n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // one datapath per matrix row
    assign w_vec = i_s_tdata;

    for (genvar r = 0; r < hvt_pkg::VEC_N; r++) begin : g_row
        hvt_row_dot #(
            .FRAC_BITS (FRAC_BITS)
        ) u_row_dot (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_row (w_matrix[r]),
            .i_vec (w_vec),
            .o_out (w_out[r])
        );
    end

    // stream handshakes
    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = w_out;

endmodule

// File: rtl/hvt_checker.sv
// ----------------------------------------------------------------------------
// hvt_checker
// Port-level checks of the vertex transform pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "homogeneous_vertex_transform_top_defines.svh"

module hvt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           o_s_tready,
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [hvt_pkg::TDATA_W-1:0]    o_m_tdata
);

    // a stalled result holds its value
    `HVT_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // with the output not stalled the input side is always open
    `HVT_ASSERT_SAME(a_in_ready, !(o_m_tvalid && !i_m_tready), o_s_tready)

    // an input transfer shows as output valid if the output does not stall while it moves through
    `HVT_ASSERT_NEXT(a_latency, i_s_tvalid && o_s_tready ##1 i_m_tready [*3], o_m_tvalid)

endmodule

bind homogeneous_vertex_transform_top hvt_checker u_hvt_checker (.*);
